// ----- sv/dsvd_pkg.sv -----
// ----------------------------------------------------------------------------
// dsvd_pkg: shared types and constants for the DLE voice deframer
// Result transaction layout, result kinds, event numbers, control characters
// and the depth of the queue that sits between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

package dsvd_pkg;

   // Control characters of the shielded stream
   localparam logic [7:0] CHR_DLE   = 8'h10;
   localparam logic [7:0] CHR_ETX   = 8'h03;
   localparam logic [7:0] CHR_ZERO  = 8'h30;   // '0'
   localparam logic [7:0] CHR_NINE  = 8'h39;   // '9'
   localparam logic [7:0] CHR_STAR  = 8'h2A;   // '*'
   localparam logic [7:0] CHR_HASH  = 8'h23;   // '#'
   localparam logic [7:0] CHR_UP_A  = 8'h41;   // 'A'
   localparam logic [7:0] CHR_UP_D  = 8'h44;   // 'D'
   localparam logic [7:0] CHR_UP_T  = 8'h54;   // 'T'
   localparam logic [7:0] CHR_LO_A  = 8'h61;   // 'a'
   localparam logic [7:0] CHR_LO_B  = 8'h62;   // 'b'
   localparam logic [7:0] CHR_LO_C  = 8'h63;   // 'c'
   localparam logic [7:0] CHR_LO_D  = 8'h64;   // 'd'
   localparam logic [7:0] CHR_LO_E  = 8'h65;   // 'e'
   localparam logic [7:0] CHR_LO_F  = 8'h66;   // 'f'
   localparam logic [7:0] CHR_LO_H  = 8'h68;   // 'h'
   localparam logic [7:0] CHR_LO_O  = 8'h6F;   // 'o'
   localparam logic [7:0] CHR_LO_Q  = 8'h71;   // 'q'
   localparam logic [7:0] CHR_LO_S  = 8'h73;   // 's'
   localparam logic [7:0] CHR_LO_T  = 8'h74;   // 't'
   localparam logic [7:0] CHR_LO_U  = 8'h75;   // 'u'

   // Result kinds
   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_EVENT   = 2'd1,
      KIND_END     = 2'd2,
      KIND_UNKNOWN = 2'd3
   } kind_type;

   // Event numbers
   typedef enum logic [3:0] {
      EV_DTMF      = 4'd0,
      EV_DATA_FAX  = 4'd1,
      EV_BUSY      = 4'd2,
      EV_FAX_CALL  = 4'd3,
      EV_DIAL      = 4'd4,
      EV_DATA_CALL = 4'd5,
      EV_ONHOOK    = 4'd6,
      EV_OFFHOOK   = 4'd7,
      EV_SILENCE   = 4'd8,
      EV_NO_ENERGY = 4'd9,
      EV_OVERRUN   = 4'd10,
      EV_UNDERRUN  = 4'd11
   } evnum_type;

   // One result transaction
   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      evnum_type  event_code;
   } result_type;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

// ----- sv/dsvd_front.sv -----
// ----------------------------------------------------------------------------
// dsvd_front: request acceptance and byte classification
// Holds the escape and finished flags, decodes each accepted byte and pushes
// at most one result transaction into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dsvd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                queue_full,
   input  wire logic [7:0]          rx_byte,
   input  wire logic                restart,
   output logic                     push,
   output dsvd_pkg::result_type     push_data
);

   logic escape_ff, escape_in;
   logic finished_ff, finished_in;
   logic accept;
   logic esc_now, fin_now;
   logic emit;
   logic is_dtmf;
   logic has_event;
   dsvd_pkg::evnum_type ev_num;
   dsvd_pkg::result_type res;

   assign accept = req_valid && !queue_full;

   // DTMF character set
   assign is_dtmf = ((rx_byte >= dsvd_pkg::CHR_ZERO) && (rx_byte <= dsvd_pkg::CHR_NINE)) ||
                    (rx_byte == dsvd_pkg::CHR_STAR) || (rx_byte == dsvd_pkg::CHR_HASH) ||
                    ((rx_byte >= dsvd_pkg::CHR_UP_A) && (rx_byte <= dsvd_pkg::CHR_UP_D));

   // Numbered event lookup
   always_comb begin
      has_event = 1'b1;
      ev_num    = dsvd_pkg::EV_DTMF;
      unique case (rx_byte)
         dsvd_pkg::CHR_LO_F, dsvd_pkg::CHR_LO_A: ev_num = dsvd_pkg::EV_DATA_FAX;
         dsvd_pkg::CHR_LO_B: ev_num = dsvd_pkg::EV_BUSY;
         dsvd_pkg::CHR_LO_C: ev_num = dsvd_pkg::EV_FAX_CALL;
         dsvd_pkg::CHR_LO_D: ev_num = dsvd_pkg::EV_DIAL;
         dsvd_pkg::CHR_LO_E: ev_num = dsvd_pkg::EV_DATA_CALL;
         dsvd_pkg::CHR_LO_H: ev_num = dsvd_pkg::EV_ONHOOK;
         dsvd_pkg::CHR_LO_T: ev_num = dsvd_pkg::EV_OFFHOOK;
         dsvd_pkg::CHR_LO_Q: ev_num = dsvd_pkg::EV_SILENCE;
         dsvd_pkg::CHR_LO_S: ev_num = dsvd_pkg::EV_NO_ENERGY;
         dsvd_pkg::CHR_LO_O: ev_num = dsvd_pkg::EV_OVERRUN;
         dsvd_pkg::CHR_LO_U: ev_num = dsvd_pkg::EV_UNDERRUN;
         default:            has_event = 1'b0;
      endcase
   end

   // Flag update and result decode
   always_comb begin
      esc_now     = restart ? 1'b0 : escape_ff;
      fin_now     = restart ? 1'b0 : finished_ff;
      escape_in   = esc_now;
      finished_in = fin_now;
      emit        = 1'b0;
      res.kind       = dsvd_pkg::KIND_DATA;
      res.value      = rx_byte;
      res.event_code = dsvd_pkg::EV_DTMF;
      priority if (fin_now) begin
         // stream ended: ignore byte
         emit = 1'b0;
      end else if (!esc_now) begin
         if (rx_byte == dsvd_pkg::CHR_DLE) begin
            escape_in = 1'b1;
         end else begin
            emit = 1'b1;
         end
      end else begin
         escape_in = 1'b0;
         priority if (rx_byte == dsvd_pkg::CHR_DLE) begin
            emit = 1'b1;
         end else if (rx_byte == dsvd_pkg::CHR_ETX) begin
            emit        = 1'b1;
            finished_in = 1'b1;
            res.kind    = dsvd_pkg::KIND_END;
            res.value   = 8'h00;
         end else if (is_dtmf) begin
            emit     = 1'b1;
            res.kind = dsvd_pkg::KIND_EVENT;
         end else if (rx_byte == dsvd_pkg::CHR_UP_T) begin
            emit = 1'b0;
         end else if (has_event) begin
            emit           = 1'b1;
            res.kind       = dsvd_pkg::KIND_EVENT;
            res.value      = 8'h00;
            res.event_code = ev_num;
         end else begin
            emit     = 1'b1;
            res.kind = dsvd_pkg::KIND_UNKNOWN;
         end
      end
   end

   assign push      = accept && emit;
   assign push_data = res;

   // Flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff   <= 1'b0;
         finished_ff <= 1'b0;
      end else if (accept) begin
         escape_ff   <= escape_in;
         finished_ff <= finished_in;
      end
   end

   // An end-of-stream result leaves the stream finished
   a_end_sets_finished: assert property (@(posedge clock) disable iff (reset)
      (push && (push_data.kind == dsvd_pkg::KIND_END)) |=> finished_ff)
      else $error("end of stream did not set finished flag");

   // A finished stream never has an escape pending
   a_fin_no_escape: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !escape_ff)
      else $error("escape pending after end of stream");

endmodule

`default_nettype wire

// ----- sv/dsvd_queue.sv -----
// ----------------------------------------------------------------------------
// dsvd_queue: short result queue between front and back
// Register-based FIFO of result transactions; full is taken from the
// registered count so the front stall has no path from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dsvd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire dsvd_pkg::result_type push_data,
   input  wire logic                pop,
   output dsvd_pkg::result_type     pop_data,
   output logic                     full,
   output logic                     empty
);

   localparam logic [dsvd_pkg::QUEUE_IDX_W-1:0] LAST_IDX =
      dsvd_pkg::QUEUE_IDX_W'(dsvd_pkg::QUEUE_DEPTH - 1);
   localparam logic [dsvd_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
      dsvd_pkg::QUEUE_CNT_W'(dsvd_pkg::QUEUE_DEPTH);

   dsvd_pkg::result_type slot_ff [dsvd_pkg::QUEUE_DEPTH];
   logic [dsvd_pkg::QUEUE_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dsvd_pkg::QUEUE_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dsvd_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- sv/dsvd_back.sv -----
// ----------------------------------------------------------------------------
// dsvd_back: response output register
// Pulls result transactions from the queue into the response register
// whenever that register is empty or being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dsvd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                queue_empty,
   input  wire dsvd_pkg::result_type queue_data,
   output logic                     pop,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_kind,
   output logic [7:0]               rsp_value,
   output logic [3:0]               rsp_event_code
);

   logic                 valid_ff, valid_in;
   dsvd_pkg::result_type data_ff;

   // Load the register when it is free or draining this cycle
   assign pop      = !queue_empty && (!valid_ff || !rsp_stall);
   assign valid_in = pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= queue_data;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = data_ff.kind;
   assign rsp_value      = data_ff.value;
   assign rsp_event_code = data_ff.event_code;

   a_pop_fills: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff)
      else $error("response register not filled after pop");

endmodule

`default_nettype wire

// ----- sv/dle_shielded_voice_deframer.sv -----
// ----------------------------------------------------------------------------
// dle_shielded_voice_deframer: DLE-shielded voice stream deframer
// Undoes DLE shielding of a voice modem byte stream and reports data bytes,
// DTMF and numbered events, end of stream and unknown codes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per transaction plus a restart bit that
//   clears the escape and finished flags before the byte is handled.
//   rsp_* carries zero or one result transaction per request: kind, value
//   and event code. Lone DLE, code 'T' and bytes after end of stream give
//   no response.
//   A result passes from the front decode into the queue, then into the
//   output register, from which it is shown on rsp_*.
//   Throughput: one request per cycle while req_stall is low; the front
//   decodes combinationally and the two-entry queue plus output register keep
//   it running while the receiver takes one response per cycle.
//   When rsp_stall is held, the output register holds its transaction, the
//   queue fills, and req_stall rises once the queue is full.
//   Reset (synchronous) clears both flags, empties the queue and drops
//   rsp_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module dle_shielded_voice_deframer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_restart,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_value,
   output logic [3:0]      rsp_event_code
);

   logic                 push;
   logic                 pop;
   logic                 queue_full;
   logic                 queue_empty;
   dsvd_pkg::result_type push_data;
   dsvd_pkg::result_type pop_data;

   assign req_stall = queue_full;

   // Front: flags and decode
   dsvd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .queue_full (queue_full),
      .rx_byte    (req_rx_byte),
      .restart    (req_restart),
      .push       (push),
      .push_data  (push_data)
   );

   // Result queue
   dsvd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // Back: response register
   dsvd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .queue_data     (pop_data),
      .pop            (pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_value      (rsp_value),
      .rsp_event_code (rsp_event_code)
   );

endmodule

`default_nettype wire
